/* rtl/core/bmi_pkg.sv */
// ----------------------------------------------------------------------------
// bmi_pkg - shared types and constants of the ball motion integrator
// Holds the sequencer states and the register indexes of the APB port.
// ----------------------------------------------------------------------------
package bmi_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_FRIC,
        ST_SQ,
        ST_SQRT,
        ST_NORM,
        ST_DRV,
        ST_FRC,
        ST_FZ,
        ST_FDIV,
        ST_DTMUL,
        ST_LIM,
        ST_DISP,
        ST_OUT
    } bmi_state_t;

    typedef logic [2:0] bmi_reg_idx_t;

    localparam bmi_reg_idx_t REG_MASS      = 3'd0;
    localparam bmi_reg_idx_t REG_GRAVITY   = 3'd1;
    localparam bmi_reg_idx_t REG_FRICTION  = 3'd2;
    localparam bmi_reg_idx_t REG_DRIVE     = 3'd3;
    localparam bmi_reg_idx_t REG_MAX_SPEED = 3'd4;

    localparam logic [0:0] OP_STEP = 1'b0;
    localparam logic [0:0] OP_LOAD = 1'b1;

    // Command to the shared divider.
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] mag;
        logic [31:0] divisor;
    } bmi_div_cmd_t;

endpackage

/* rtl/core/ball_motion_integrator.sv */
// ----------------------------------------------------------------------------
// ball_motion_integrator - velocity integrator for a rolling ball
// Keeps a 3-D velocity, integrates it over one time step per step beat,
// clamps the planar speed and reports the displacement of the step.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    op, dir_x/y/z, delta_time, load_vx/y/z
//   m_        out        m_valid/m_ready    disp_x/y/z, vel_out_x/y/z
//   APB       in         psel/penable       mass, gravity, friction, drive, max speed
//
// A step beat runs about 8 divisions on the shared divider, two square
// roots and 21 multiplies on the shared multiplier. Reset clears the
// velocity and loads the register defaults. s_ready is high only while the
// sequencer is idle; a finished result waits in the output register while
// the next beat is taken.
//
module ball_motion_integrator
    import bmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_dir_x,
    input  logic signed [31:0] s_dir_y,
    input  logic signed [31:0] s_dir_z,
    input  logic [30:0]        s_delta_time,
    input  logic signed [31:0] s_load_vx,
    input  logic signed [31:0] s_load_vy,
    input  logic signed [31:0] s_load_vz,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_disp_x,
    output logic signed [31:0] m_disp_y,
    output logic signed [31:0] m_disp_z,
    output logic signed [31:0] m_vel_out_x,
    output logic signed [31:0] m_vel_out_y,
    output logic signed [31:0] m_vel_out_z
);

    // The 0.1 dead band around zero, rounded to the fixed point grid.
    localparam logic signed [31:0] TENTH = 32'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] W_MAX = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN = -66'sd2147483648;
    localparam logic [30:0] MASS_RESET = 31'(1 << FRAC_BITS);

    // Saturate a 33 bit sum or difference to 32 bits.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] y;
        if (x > 33'sd2147483647) begin
            y = S32_MAX;
        end else if (x < -33'sd2147483648) begin
            y = S32_MIN;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // Clamp a planar velocity to its limit, then apply the dead band.
    function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] v,
                                                      input logic signed [31:0] lim);
        logic signed [31:0] y;
        if (v > 0 && v > lim) begin
            y = lim;
        end else if (v < 0 && v < lim) begin
            y = lim;
        end else if (v > -TENTH && v < TENTH) begin
            y = 32'sd0;
        end else begin
            y = v;
        end
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0]        mass_reg;
    logic signed [31:0] gravity_reg;
    logic [30:0]        friction_reg;
    logic signed [31:0] drive_reg;
    logic [30:0]        max_speed_reg;
    bmi_reg_idx_t       cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_MASS:      prdata = {1'b0, mass_reg};
            REG_GRAVITY:   prdata = gravity_reg;
            REG_FRICTION:  prdata = {1'b0, friction_reg};
            REG_DRIVE:     prdata = drive_reg;
            REG_MAX_SPEED: prdata = {1'b0, max_speed_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg      <= MASS_RESET;
            gravity_reg   <= 32'sd0;
            friction_reg  <= 31'd0;
            drive_reg     <= 32'sd0;
            max_speed_reg <= 31'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MASS:      mass_reg      <= pwdata[30:0];
                REG_GRAVITY:   gravity_reg   <= pwdata;
                REG_FRICTION:  friction_reg  <= pwdata[30:0];
                REG_DRIVE:     drive_reg     <= pwdata;
                REG_MAX_SPEED: max_speed_reg <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    bmi_state_t         state_reg, state_next;
    logic               phase_reg, phase_next;
    logic [1:0]         comp_reg, comp_next;
    logic               pass_reg, pass_next;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] nv_reg [3];
    logic signed [31:0] nv_next [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] dir_next [3];
    logic signed [31:0] f_reg [3];
    logic signed [31:0] f_next [3];
    logic signed [31:0] n_reg [3];
    logic signed [31:0] n_next [3];
    logic signed [31:0] disp_reg [3];
    logic signed [31:0] disp_next [3];
    logic [30:0]        dt_reg, dt_next;
    logic signed [31:0] weight_reg, weight_next;
    logic signed [31:0] fric_reg, fric_next;
    logic signed [31:0] tmp_reg, tmp_next;
    logic [63:0]        acc_reg, acc_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_disp_reg [3];
    logic signed [31:0] m_vel_reg [3];
    logic               out_load;

    // Shared units.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] p_sh;
    logic signed [31:0] fm;
    bmi_div_cmd_t       div_cmd;
    logic signed [31:0] div_src;
    logic               div_done;
    logic signed [31:0] div_quo;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               last_norm;

    bmi_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    bmi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .done    (div_done),
        .quo     (div_quo)
    );

    bmi_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     (acc_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Fixed point product: floor shift, then saturate.
    assign p_sh = mul_p >>> FRAC_BITS;

    always_comb begin
        if (p_sh > W_MAX) begin
            fm = S32_MAX;
        end else if (p_sh < W_MIN) begin
            fm = S32_MIN;
        end else begin
            fm = p_sh[31:0];
        end
    end

    // Multiplier operands, chosen by the step being worked on.
    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        unique case (state_reg)
            ST_WEIGHT: begin
                mul_a = {2'b00, mass_reg};
                mul_b = {gravity_reg[31], gravity_reg};
            end
            ST_FRIC: begin
                mul_a = {2'b00, friction_reg};
                mul_b = {weight_reg[31], weight_reg};
            end
            ST_SQ: begin
                if (pass_reg) begin
                    mul_a = {nv_reg[comp_reg][31], nv_reg[comp_reg]};
                end else begin
                    mul_a = {vel_reg[comp_reg][31], vel_reg[comp_reg]};
                end
                mul_b = mul_a;
            end
            ST_DRV: begin
                mul_a = {dir_reg[comp_reg][31], dir_reg[comp_reg]};
                mul_b = {drive_reg[31], drive_reg};
            end
            ST_FRC: begin
                mul_a = {n_reg[comp_reg][31], n_reg[comp_reg]};
                mul_b = {fric_reg[31], fric_reg};
            end
            ST_FZ: begin
                mul_a = {dir_reg[2][31], dir_reg[2]};
                mul_b = {weight_reg[31], weight_reg};
            end
            ST_DTMUL: begin
                mul_a = {div_quo[31], div_quo};
                mul_b = {2'b00, dt_reg};
            end
            ST_LIM: begin
                mul_a = {n_reg[comp_reg][31], n_reg[comp_reg]};
                mul_b = {2'b00, max_speed_reg};
            end
            ST_DISP: begin
                mul_a = {vel_reg[comp_reg][31], vel_reg[comp_reg]}
                      + {nv_reg[comp_reg][31], nv_reg[comp_reg]};
                mul_b = {2'b00, dt_reg};
            end
            default: begin
            end
        endcase
    end

    // Divider command: a normalization divides by the vector length, a
    // force divides by the mass.
    always_comb begin
        if (state_reg == ST_NORM) begin
            div_src         = pass_reg ? nv_reg[comp_reg] : vel_reg[comp_reg];
            div_cmd.divisor = sqrt_root;
        end else begin
            div_src         = f_reg[comp_reg];
            div_cmd.divisor = {1'b0, mass_reg};
        end
        div_cmd.neg   = div_src[31];
        div_cmd.mag   = div_src[31] ? 32'(-div_src) : div_src;
        div_cmd.start = !phase_reg && (state_reg == ST_FDIV ||
                        (state_reg == ST_NORM && sqrt_root != 32'd0));
    end

    assign sqrt_start = (state_reg == ST_SQRT) && !phase_reg;
    // The second normalization only needs the planar components.
    assign last_norm  = pass_reg ? (comp_reg == 2'd1) : (comp_reg == 2'd2);
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        comp_next  = comp_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_IDLE: begin
                phase_next = 1'b0;
                comp_next  = 2'd0;
                pass_next  = 1'b0;
                if (s_valid) begin
                    state_next = (s_op == OP_LOAD) ? ST_OUT : ST_WEIGHT;
                end
            end
            ST_WEIGHT, ST_DRV: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = (state_reg == ST_WEIGHT) ? ST_FRIC : ST_FRC;
                end
            end
            ST_FRIC: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (comp_reg == 2'd2) begin
                        comp_next  = 2'd0;
                        state_next = ST_SQRT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ST_SQRT: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (sqrt_done) begin
                    phase_next = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if ((!phase_reg && sqrt_root == 32'd0) || (phase_reg && div_done)) begin
                    phase_next = 1'b0;
                    if (last_norm) begin
                        comp_next  = 2'd0;
                        state_next = pass_reg ? ST_LIM : ST_DRV;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end
            end
            ST_FRC: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (comp_reg == 2'd1) begin
                        comp_next  = 2'd0;
                        state_next = ST_FZ;
                    end else begin
                        comp_next  = 2'd1;
                        state_next = ST_DRV;
                    end
                end
            end
            ST_FZ: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (div_done) begin
                    phase_next = 1'b0;
                    state_next = ST_DTMUL;
                end
            end
            ST_DTMUL: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (comp_reg == 2'd2) begin
                        comp_next  = 2'd0;
                        pass_next  = 1'b1;
                        state_next = ST_SQ;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_FDIV;
                    end
                end
            end
            ST_LIM: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (comp_reg == 2'd1) begin
                        comp_next  = 2'd0;
                        state_next = ST_DISP;
                    end else begin
                        comp_next = 2'd1;
                    end
                end
            end
            ST_DISP: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (comp_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Working register updates. Results of a multiply are taken in the
    // second phase of its step, in the cycle after the operands were set.
    always_comb begin
        vel_next    = vel_reg;
        nv_next     = nv_reg;
        dir_next    = dir_reg;
        f_next      = f_reg;
        n_next      = n_reg;
        disp_next   = disp_reg;
        dt_next     = dt_reg;
        weight_next = weight_reg;
        fric_next   = fric_reg;
        tmp_next    = tmp_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                acc_next = 64'd0;
                if (s_valid) begin
                    dir_next[0] = s_dir_x;
                    dir_next[1] = s_dir_y;
                    dir_next[2] = s_dir_z;
                    dt_next     = s_delta_time;
                    if (s_op == OP_LOAD) begin
                        vel_next[0]  = s_load_vx;
                        vel_next[1]  = s_load_vy;
                        vel_next[2]  = s_load_vz;
                        disp_next[0] = 32'sd0;
                        disp_next[1] = 32'sd0;
                        disp_next[2] = 32'sd0;
                    end
                end
            end
            ST_WEIGHT: begin
                if (phase_reg) begin
                    weight_next = fm;
                end
            end
            ST_FRIC: begin
                if (phase_reg) begin
                    fric_next = fm;
                end
            end
            ST_SQ: begin
                if (phase_reg) begin
                    acc_next = acc_reg + mul_p[63:0];
                end
            end
            ST_NORM: begin
                if (!phase_reg && sqrt_root == 32'd0) begin
                    n_next[comp_reg] = 32'sd0;
                end else if (phase_reg && div_done) begin
                    n_next[comp_reg] = div_quo;
                end
            end
            ST_DRV: begin
                if (phase_reg) begin
                    tmp_next = fm;
                end
            end
            ST_FRC: begin
                if (phase_reg) begin
                    f_next[comp_reg] = sat33({tmp_reg[31], tmp_reg} - {fm[31], fm});
                end
            end
            ST_FZ: begin
                if (phase_reg) begin
                    f_next[2] = fm;
                end
            end
            ST_DTMUL: begin
                if (phase_reg) begin
                    nv_next[comp_reg] = sat33({vel_reg[comp_reg][31], vel_reg[comp_reg]}
                                              + {fm[31], fm});
                    acc_next = 64'd0;
                end
            end
            ST_LIM: begin
                if (phase_reg) begin
                    nv_next[comp_reg] = clamp_axis(nv_reg[comp_reg], fm);
                end
            end
            ST_DISP: begin
                if (phase_reg) begin
                    disp_next[comp_reg] = fm;
                    if (comp_reg == 2'd2) begin
                        vel_next = nv_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: holds a finished beat until the sink takes it.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            comp_reg    <= 2'd0;
            pass_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            vel_reg[0]  <= 32'sd0;
            vel_reg[1]  <= 32'sd0;
            vel_reg[2]  <= 32'sd0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            comp_reg    <= comp_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
            vel_reg     <= vel_next;
        end
    end

    always_ff @(posedge aclk) begin
        nv_reg     <= nv_next;
        dir_reg    <= dir_next;
        f_reg      <= f_next;
        n_reg      <= n_next;
        disp_reg   <= disp_next;
        dt_reg     <= dt_next;
        weight_reg <= weight_next;
        fric_reg   <= fric_next;
        tmp_reg    <= tmp_next;
        acc_reg    <= acc_next;
        if (out_load) begin
            m_disp_reg <= disp_reg;
            m_vel_reg  <= vel_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_disp_x    = m_disp_reg[0];
    assign m_disp_y    = m_disp_reg[1];
    assign m_disp_z    = m_disp_reg[2];
    assign m_vel_out_x = m_vel_reg[0];
    assign m_vel_out_y = m_vel_reg[1];
    assign m_vel_out_z = m_vel_reg[2];

endmodule

/* rtl/core/bmi_mul.sv */
// ----------------------------------------------------------------------------
// bmi_mul - shared registered multiplier
// Signed 33 by 33 bit product, registered.
// ----------------------------------------------------------------------------
module bmi_mul (
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

/* rtl/core/bmi_div.sv */
// ----------------------------------------------------------------------------
// bmi_div - iterative fixed point divider
// Computes (x << FRAC_BITS) / d one quotient bit a cycle, truncated toward
// zero and saturated to 32 bits. A zero divisor saturates by the sign of x.
// ----------------------------------------------------------------------------
module bmi_div
    import bmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bmi_div_cmd_t       cmd,
    output logic               done,
    output logic signed [31:0] quo
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] POS_LIM = DW'(32'h7FFF_FFFF);
    localparam logic [DW-1:0] NEG_LIM = DW'(32'h8000_0000);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [31:0]   dsr_reg, dsr_next;
    logic          neg_reg, neg_next;
    logic [31:0]   quo_reg, quo_next;
    logic [32:0]   rem_sh;
    logic          ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, dvd_reg[DW-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        if (cmd.start) begin
            if (cmd.divisor == 32'd0) begin
                done_next = 1'b1;
                if (cmd.mag == 32'd0) begin
                    quo_next = 32'd0;
                end else if (cmd.neg) begin
                    quo_next = 32'h8000_0000;
                end else begin
                    quo_next = 32'h7FFF_FFFF;
                end
            end else begin
                busy_next = 1'b1;
                cnt_next  = CW'(DW);
                rem_next  = 32'd0;
                dvd_next  = {cmd.mag, {FRAC_BITS{1'b0}}};
                dsr_next  = cmd.divisor;
                neg_next  = cmd.neg;
            end
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_next = ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                dvd_next = {dvd_reg[DW-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg) begin
                    quo_next = (dvd_reg > NEG_LIM) ? 32'h8000_0000 : 32'(-dvd_reg);
                end else begin
                    quo_next = (dvd_reg > POS_LIM) ? 32'h7FFF_FFFF : dvd_reg[31:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/core/bmi_sqrt.sv */
// ----------------------------------------------------------------------------
// bmi_sqrt - iterative integer square root
// Floor square root of a 64 bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module bmi_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        s_next    = s_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            s_next    = rad;
            r_next    = 64'd0;
            bit_next  = 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (s_reg >= trial) begin
                s_next = s_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for the ball motion integrator
// Drives step and load beats with random gaps and back pressure, predicts
// results from its own fixed-point model or from typed expectations, and compares
// each result beat field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb;
    import bmi_pkg::*;

    localparam int FRAC = 16;
    localparam longint ONE_FX = longint'(1) << FRAC;
    localparam longint TENTH_FX = (ONE_FX + 5) / 10;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam bmi_reg_idx_t REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 152;

    typedef struct {
        logic signed [31:0] disp[3];
        logic signed [31:0] vel[3];
    } motion_t;

    typedef struct {
        logic               op;
        logic signed [31:0] dir[3];
        logic [30:0]        dt;
        logic signed [31:0] load[3];
        bit                 typed;
        motion_t            exp_res;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic signed [31:0] s_dir_x = '0;
    logic signed [31:0] s_dir_y = '0;
    logic signed [31:0] s_dir_z = '0;
    logic [30:0]        s_delta_time = '0;
    logic signed [31:0] s_load_vx = '0;
    logic signed [31:0] s_load_vy = '0;
    logic signed [31:0] s_load_vz = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_disp_x;
    logic signed [31:0] m_disp_y;
    logic signed [31:0] m_disp_z;
    logic signed [31:0] m_vel_out_x;
    logic signed [31:0] m_vel_out_y;
    logic signed [31:0] m_vel_out_z;

    ball_motion_integrator #(.FRAC_BITS(FRAC)) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_dir_x     (s_dir_x),
        .s_dir_y     (s_dir_y),
        .s_dir_z     (s_dir_z),
        .s_delta_time(s_delta_time),
        .s_load_vx   (s_load_vx),
        .s_load_vy   (s_load_vy),
        .s_load_vz   (s_load_vz),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_disp_x    (m_disp_x),
        .m_disp_y    (m_disp_y),
        .m_disp_z    (m_disp_z),
        .m_vel_out_x (m_vel_out_x),
        .m_vel_out_y (m_vel_out_y),
        .m_vel_out_z (m_vel_out_z)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the registers and the velocity held by the block.
    longint  cfg_mass, cfg_gravity, cfg_friction, cfg_drive, cfg_max_speed;
    longint  ball_vel[3];
    motion_t pending_motion[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      calm_phase = 1'b0;   // when set, neither side inserts gaps

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the block.
    // ------------------------------------------------------------------
    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Product floored to the fraction width; the arithmetic shift rounds
    // toward minus infinity for negative products.
    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return sat32(p >>> FRAC);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (b == 0) begin
            if (a > 0) return S32_MAX;
            if (a < 0) return S32_MIN;
            return 0;
        end
        return sat32((a * ONE_FX) / b);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, bit_pos;
        r = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > s) bit_pos = bit_pos >> 2;
        while (bit_pos != 0) begin
            if (s >= r + bit_pos) begin
                s = s - (r + bit_pos);
                r = (r >> 1) + bit_pos;
            end else begin
                r = r >> 1;
            end
            bit_pos = bit_pos >> 2;
        end
        return r;
    endfunction

    // Unit vector; a zero vector normalizes to zero.
    task automatic unit_vector(input longint c[3], output longint u[3]);
        longint unsigned sum_sq;
        longint len;
        sum_sq = 0;
        for (int i = 0; i < 3; i++) sum_sq += longint'(c[i] * c[i]);
        len = longint'(int_sqrt(sum_sq));
        for (int i = 0; i < 3; i++) u[i] = (len == 0) ? 0 : sat32((c[i] * ONE_FX) / len);
    endtask

    function automatic longint clamp_planar(longint v, longint lim);
        if (v > 0 && v > lim) return lim;
        if (v < 0 && v < lim) return lim;
        if (v > -TENTH_FX && v < TENTH_FX) return 0;
        return v;
    endfunction

    // Advances the shadow velocity by one beat and returns the result beat.
    task automatic integrate_beat(input stim_row_t row, output motion_t res);
        longint weight, fric, dt;
        longint n0[3], n1[3], frc[3], nv[3], disp[3];
        for (int i = 0; i < 3; i++) disp[i] = 0;
        if (row.op == OP_LOAD) begin
            for (int i = 0; i < 3; i++) ball_vel[i] = longint'(row.load[i]);
        end else begin
            dt = longint'({1'b0, row.dt});
            weight = fx_mul(cfg_mass, cfg_gravity);
            fric = fx_mul(cfg_friction, weight);
            unit_vector(ball_vel, n0);
            for (int i = 0; i < 2; i++)
                frc[i] = sat32(fx_mul(row.dir[i], cfg_drive) - fx_mul(n0[i], fric));
            frc[2] = fx_mul(row.dir[2], weight);
            for (int i = 0; i < 3; i++)
                nv[i] = sat32(ball_vel[i] + fx_mul(fx_div(frc[i], cfg_mass), dt));
            unit_vector(nv, n1);
            for (int i = 0; i < 2; i++)
                nv[i] = clamp_planar(nv[i], fx_mul(n1[i], cfg_max_speed));
            // Old plus new velocity is kept exact before the multiply.
            for (int i = 0; i < 3; i++) begin
                disp[i] = fx_mul(ball_vel[i] + nv[i], dt);
                ball_vel[i] = nv[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.disp[i] = disp[i][31:0];
            res.vel[i] = ball_vel[i][31:0];
        end
    endtask

    // ------------------------------------------------------------------
    // Configuration port. A write is followed by a read-back of the same
    // register; indexes past the list must leave the registers untouched.
    // ------------------------------------------------------------------
    task automatic write_register(input bmi_reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] expect_val;
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_MASS:      cfg_mass      = longint'({1'b0, value[30:0]});
            REG_GRAVITY:   cfg_gravity   = longint'($signed(value));
            REG_FRICTION:  cfg_friction  = longint'({1'b0, value[30:0]});
            REG_DRIVE:     cfg_drive     = longint'($signed(value));
            REG_MAX_SPEED: cfg_max_speed = longint'({1'b0, value[30:0]});
            default: ;
        endcase
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel <= 1'b0; penable <= 1'b0;
        if (idx <= REG_MAX_SPEED) begin
            expect_val = (idx == REG_GRAVITY || idx == REG_DRIVE) ? value
                                                                 : {1'b0, value[30:0]};
            if (readback !== expect_val) begin
                $error("register %0d: expected %h, actual %h", idx, expect_val, readback);
                error_count++;
            end
        end
    endtask

    task automatic write_all(input logic [31:0] m, input logic [31:0] g,
                             input logic [31:0] f, input logic [31:0] d,
                             input logic [31:0] v);
        write_register(REG_MASS, m);
        write_register(REG_GRAVITY, g);
        write_register(REG_FRICTION, f);
        write_register(REG_DRIVE, d);
        write_register(REG_MAX_SPEED, v);
    endtask

    // ------------------------------------------------------------------
    // Input channel. Valid stays high across back-to-back beats; it drops
    // only when a gap is drawn or the stream ends.
    // ------------------------------------------------------------------
    task automatic send_beat(input stim_row_t row, input bit use_typed);
        int gap;
        motion_t predicted;
        gap = calm_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= row.op;
        s_dir_x <= row.dir[0]; s_dir_y <= row.dir[1]; s_dir_z <= row.dir[2];
        s_delta_time <= row.dt;
        s_load_vx <= row.load[0]; s_load_vy <= row.load[1]; s_load_vz <= row.load[2];
        do @(posedge aclk); while (!s_ready);
        integrate_beat(row, predicted);
        pending_motion.push_back((use_typed && row.typed) ? row.exp_res : predicted);
    endtask

    // Called at the edge that took the last beat, so valid drops at once.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly values near unit scale so that the physics stays in range,
    // with full-range words and the extremes mixed in.
    function automatic logic signed [31:0] rand_fx();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: case ($urandom_range(0, 4))
                   0: return 32'sh7fffffff;
                   1: return 32'sh80000000;
                   2: return 0;
                   3: return -1;
                   default: return 1;
               endcase
            2: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic stim_row_t rand_row();
        stim_row_t row;
        row.op = ($urandom_range(0, 7) == 0) ? OP_LOAD : OP_STEP;
        for (int i = 0; i < 3; i++) begin
            row.dir[i] = rand_fx();
            row.load[i] = rand_fx();
        end
        case ($urandom_range(0, 9))
            0: row.dt = 31'($urandom);
            1: row.dt = 31'd0;
            default: row.dt = 31'($urandom_range(0, 1 << 17));
        endcase
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t mk_row(logic op, logic signed [31:0] a,
                                         logic signed [31:0] b, logic signed [31:0] c,
                                         logic [30:0] dt, bit typed);
        stim_row_t row;
        row.op = op;
        row.dt = dt;
        row.typed = typed;
        for (int i = 0; i < 3; i++) begin
            row.dir[i] = 0;
            row.load[i] = 0;
            row.exp_res.disp[i] = 0;
        end
        if (op == OP_LOAD) begin
            row.load[0] = a; row.load[1] = b; row.load[2] = c;
        end else begin
            row.dir[0] = a; row.dir[1] = b; row.dir[2] = c;
        end
        // Typed expectations: a load reports zero displacement and the loaded
        // velocity; a step from rest with no forces stays at rest.
        row.exp_res.vel[0] = row.load[0];
        row.exp_res.vel[1] = row.load[1];
        row.exp_res.vel[2] = row.load[2];
        return row;
    endfunction

    stim_row_t directed[$];

    // ------------------------------------------------------------------
    // Result channel: back pressure drawn once per beat.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        int next_stall;
        next_stall = stall_left;
        if (m_valid && m_ready) begin
            next_stall = calm_phase ? 0 : $urandom_range(0, 3);
        end else if (next_stall > 0) begin
            next_stall--;
        end
        stall_left <= next_stall;
        m_ready <= aresetn && (next_stall == 0);
    end

    always @(posedge aclk) begin
        motion_t got, want;
        if (m_valid && m_ready) begin
            got.disp[0] = m_disp_x; got.disp[1] = m_disp_y; got.disp[2] = m_disp_z;
            got.vel[0] = m_vel_out_x; got.vel[1] = m_vel_out_y; got.vel[2] = m_vel_out_z;
            if (pending_motion.size() == 0) begin
                $error("result beat with no expectation waiting");
                error_count++;
            end else begin
                want = pending_motion.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got.disp[i] !== want.disp[i]) begin
                        $error("disp[%0d]: expected %0d, actual %0d", i, want.disp[i],
                               got.disp[i]);
                        error_count++;
                    end
                    if (got.vel[i] !== want.vel[i]) begin
                        $error("vel_out[%0d]: expected %0d, actual %0d", i, want.vel[i],
                               got.vel[i]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cfg_mass = ONE_FX;
        cfg_gravity = 0; cfg_friction = 0; cfg_drive = 0; cfg_max_speed = 0;
        for (int i = 0; i < 3; i++) ball_vel[i] = 0;

        directed.push_back(mk_row(OP_STEP, 0, 0, 0, 31'h10000, 1'b1));
        directed.push_back(mk_row(OP_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sh1234, 31'd0,
                                  1'b1));
        directed.push_back(mk_row(OP_STEP, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                  31'h7fffffff, 1'b0));
        directed.push_back(mk_row(OP_LOAD, 32'sh80000000, 32'sh7fffffff, -1, 31'd0, 1'b1));
        directed.push_back(mk_row(OP_STEP, 0, 0, 0, 31'd0, 1'b0));
        // Velocities just inside and just outside the 0.1 dead zone.
        directed.push_back(mk_row(OP_LOAD, 6553, -6553, 6554, 31'd0, 1'b1));
        directed.push_back(mk_row(OP_STEP, 32'sh10000, 0, 32'sh10000, 31'h10000, 1'b0));
        directed.push_back(mk_row(OP_LOAD, 0, 0, 0, 31'd0, 1'b1));
        directed.push_back(mk_row(OP_STEP, -32'sh10000, -32'sh10000, -32'sh10000,
                                  31'h8000, 1'b0));
        directed.push_back(mk_row(OP_LOAD, 32'sha0000, -32'sh30000, 32'sh10000, 31'd0,
                                  1'b1));
        directed.push_back(mk_row(OP_STEP, 32'sh10000, 32'sh10000, 0, 31'h10000, 1'b0));
        directed.push_back(mk_row(OP_LOAD, 32'sh20000, 32'sh0, -32'sh50000, 31'd0, 1'b1));
        directed.push_back(mk_row(OP_STEP, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                  31'h7fffffff, 1'b0));
        directed.push_back(mk_row(OP_STEP, 1, -1, 1, 31'h1, 1'b0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass under the reset defaults, with typed expectations.
        foreach (directed[k]) send_beat(directed[k], 1'b1);
        drain_results();

        // Same table under extreme settings: zero mass divides by zero, and
        // an index past the register list must change nothing.
        write_all(32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        write_register(REG_UNUSED, 32'hffffffff);
        foreach (directed[k]) send_beat(directed[k], 1'b0);
        drain_results();

        write_all(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff, 32'h0);
        foreach (directed[k]) send_beat(directed[k], 1'b0);
        drain_results();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm_phase = (ph % 4 == 3);
            if (ph % 5 == 4)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                write_all($urandom_range(1 << 12, 1 << 19),
                          $signed($urandom_range(0, 1 << 21)) - (1 << 20),
                          $urandom_range(0, 1 << 16),
                          $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                          $urandom_range(0, 1 << 22));
            for (int n = 0; n < PHASE_ITEMS; n++) send_beat(rand_row(), 1'b0);
            drain_results();
        end

        repeat (600) @(posedge aclk);
        if (error_count == 0 && pending_motion.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
